FILE: hw/rtl/ct3_pkg.sv
// ct3_pkg: shared constants, types and the census compare function for the
// 3x3 census transform unit. No dependencies.

package ct3_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int PIXEL_BITS  = 8;
	localparam int COL_BITS    = $clog2(MAX_WIDTH);
	localparam int WIDTH_BITS  = 11;
	localparam int HEIGHT_BITS = 12;
	localparam int CODE_BITS   = 8;

	// output queue
	localparam int OUT_DEPTH = 4;
	localparam int OPTR_BITS = $clog2(OUT_DEPTH);
	localparam int OCNT_BITS = $clog2(OUT_DEPTH + 1);

	// register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	typedef struct packed {
		logic                 last;
		logic [CODE_BITS-1:0] code;
	} out_word_t;

	// bit i set when neighbour i is <= centre; nb[7] is top-left
	function automatic logic [CODE_BITS-1:0] census8(
		input pix_t                           ctr,
		input logic [CODE_BITS-1:0][PIXEL_BITS-1:0] nb
	);
		logic [CODE_BITS-1:0] code;
		code = '0;
		for (int i = 0; i < CODE_BITS; i++) begin
			code[i] = (nb[i] <= ctr);
		end
		return code;
	endfunction

endpackage

FILE: hw/rtl/ct3_out_fifo.sv
// ct3_out_fifo: small register queue that holds finished census words
// until the downstream side takes them. Depends on ct3_pkg.

module ct3_out_fifo
	import ct3_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  out_word_t            push_word,
	input  logic                 pop,
	output out_word_t            head_word,
	output logic [OCNT_BITS-1:0] count
);

	out_word_t             slot_q [OUT_DEPTH];
	logic [OPTR_BITS-1:0]  wptr_q;
	logic [OPTR_BITS-1:0]  rptr_q;
	logic [OCNT_BITS-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_word;
		end
	end

	assign head_word = slot_q[rptr_q];
	assign count     = count_q;

endmodule

FILE: hw/rtl/census_transform_3x3_unit.sv
// census_transform_3x3_unit: top level of the 3x3 census transform.
// Holds the line store memory, window and counters; uses ct3_pkg and ct3_out_fifo.
//
// Channel   Dir  Fields (lsb first)                  Word moves when
// s_*       in   tdata: pixel_value[7:0]             s_tvalid & s_tready
// m_*       out  tdata: census_code[7:0]; tlast:     m_tvalid & m_tready
//                frame_last
// cfg_*     in   index 0 image_width, 1 height;      cfg_valid & cfg_ready
//                data: value in low bits
//
// One pixel word per clock sustained while s_tready is high. Stage 0 takes the
// word, steps the column/row counters and reads the line store entry for its
// column; stage 1 gets the two stored pixels in the next cycle, forms the code,
// writes the entry back and shifts the window. A four-word output queue
// decouples the sides; s_tready drops only when that queue could not take what
// is in flight. Reset clears counters, window and queue; the line store is not
// cleared (both rows of an entry valid once two rows are in).

module census_transform_3x3_unit
	import ct3_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// pixel in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel_value
	// census out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] census_code
	output logic        m_tlast,   // frame_last
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	// line store: one entry per column, {row r-1, row r-2}
	logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
	logic [2*PIXEL_BITS-1:0] line_rd_q;

	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [COL_BITS-1:0]    col_q;
	logic [HEIGHT_BITS-1:0] row_q;

	// window: index 0..2 column c-2 (top/mid/bot), 3..5 column c-1
	pix_t win_q [6];

	logic                in_acc;
	logic [WIDTH_BITS-1:0]  w_eff;
	logic [HEIGHT_BITS-1:0] h_eff;
	logic                col_end;
	logic                row_end;
	pix_t                px_in;

	// stage 1
	logic                v_s1;
	logic                emit_s1;
	logic                last_s1;
	pix_t                px_s1;
	logic [COL_BITS-1:0] col_s1;

	pix_t                top_s1;
	pix_t                mid_s1;
	logic [CODE_BITS-1:0] code_s1;
	out_word_t           push_word;
	out_word_t           head_word;
	logic [OCNT_BITS-1:0] out_count;
	logic                pop;

	assign cfg_ready = 1'b1;
	assign px_in     = s_tdata[PIXEL_BITS-1:0];

	// room for whatever is in stage 1 plus one more
	assign s_tready = ({1'b0, out_count} + {{OCNT_BITS{1'b0}}, v_s1})
		< (OCNT_BITS+1)'(OUT_DEPTH);
	assign in_acc   = s_tvalid && s_tready;

	// clamp geometry
	always_comb begin
		priority if (width_q < WIDTH_BITS'(3)) begin
			w_eff = WIDTH_BITS'(3);
		end else if (width_q > WIDTH_BITS'(MAX_WIDTH)) begin
			w_eff = WIDTH_BITS'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q < HEIGHT_BITS'(3)) ? HEIGHT_BITS'(3) : height_q;
	end

	assign col_end = (WIDTH_BITS'(col_q) + WIDTH_BITS'(1)) >= w_eff;
	assign row_end = ({1'b0, row_q} + (HEIGHT_BITS+1)'(1)) >= {1'b0, h_eff};

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_BITS'(640);
			height_q <= HEIGHT_BITS'(480);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// stage 0: counters and stage handover
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			if (in_acc) begin
				emit_s1 <= (col_q >= COL_BITS'(2)) && (row_q >= HEIGHT_BITS'(2));
				last_s1 <= col_end && row_end;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1  <= px_in;
			col_s1 <= col_q;
		end
	end

	// line store: read on accept, write back from stage 1. Back-to-back words
	// always touch different columns, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			line_rd_q <= line_mem[col_q];
		end
		if (v_s1) begin
			line_mem[col_s1] <= {px_s1, mid_s1};
		end
	end

	assign top_s1 = line_rd_q[PIXEL_BITS-1:0];
	assign mid_s1 = line_rd_q[2*PIXEL_BITS-1:PIXEL_BITS];

	// stage 1: compare against centre (mid of column c-1)
	assign code_s1 = census8(win_q[4],
		{win_q[0], win_q[3], top_s1, win_q[1], mid_s1, win_q[2], win_q[5], px_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= px_s1;
		end
	end

	assign push_word.last = last_s1;
	assign push_word.code = code_s1;
	assign pop            = m_tvalid && m_tready;

	ct3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s1 && emit_s1),
		.push_word (push_word),
		.pop       (pop),
		.head_word (head_word),
		.count     (out_count)
	);

	assign m_tvalid = (out_count != '0);
	assign m_tdata  = head_word.code;
	assign m_tlast  = head_word.last;

endmodule

FILE: hw/rtl/ct3_checker.sv
// ct3_checker: port-level checks on census_transform_3x3_unit, bound to it
// below. Depends only on the top level's ports.

module ct3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	// a held word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	// a held word keeps its contents
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// an empty output side is only refilled by a pixel accepted earlier at the input
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output word without matching input two cycles earlier");

	// input only backs off when results are waiting
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with nothing waiting at the output");

endmodule

bind census_transform_3x3_unit ct3_checker u_ct3_checker (.*);
